// File: rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int MODE_W  = 3;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK       = 3'd4
  } mode_t;

  typedef struct packed {
    logic exec;
    logic load;
  } cdq_cmd_t;

endpackage

// File: rtl/circular_double_ended_queue.sv
// Bounded circular double-ended queue of signed words.
// The input channel (in_valid, in_stall, in_mode, in_value) takes one request
// per beat: push front, push rear, pop front, pop rear or peek. The result
// channel (out_valid, out_stall, out_*) returns one beat per request with the
// success flag, front and rear words, empty and full flags and entry count,
// all as they stand after the request.
// Accepting a request updates the pointers and writes the slot. In S_READ the
// head and tail slots are read into registers, and in S_LOAD the output
// register is loaded once the output is free. The block takes no new request
// until the result of the last one is loaded (in_stall is high meanwhile).
// A finished result waits in the output register while out_stall is high,
// and the next request may already be accepted meanwhile; its result is
// held back until the waiting beat is taken.
// cfg_wr_en with cfg_wr_data sets the capacity (saturated to 1..DEPTH) and
// empties the queue. Reset sets the capacity to DEPTH and empties the queue.
module circular_double_ended_queue #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdq_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [WORD_BITS-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_success,
  output logic signed [WORD_BITS-1:0]   out_front_word,
  output logic signed [WORD_BITS-1:0]   out_rear_word,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic [cdq_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                          cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0]     cfg_wr_data
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_success     (out_success),
    .out_front_word  (out_front_word),
    .out_rear_word   (out_rear_word),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count)
  );

endmodule

// File: rtl/cdq_ctrl.sv
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.exec  = 1'b0;
    cmd.load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == S_READ))
    else $error("Accepted request did not move on to the read cycle.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("Loaded result was not presented.");

endmodule

// File: rtl/cdq_datapath.sv
module cdq_datapath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdq_pkg::cdq_cmd_t             cmd,
  input  logic [cdq_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [WORD_BITS-1:0]   in_value,
  input  logic                          cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0]     cfg_wr_data,
  output logic                          out_success,
  output logic signed [WORD_BITS-1:0]   out_front_word,
  output logic signed [WORD_BITS-1:0]   out_rear_word,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic [cdq_pkg::COUNT_W-1:0]   out_entry_count
);
  import cdq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, cap_r, cap_nxt;
  logic             ok_r, ok_nxt;
  logic [WORD_BITS-1:0] rd_front_r, rd_rear_r;

  logic [IDX_W-1:0] head_up, head_dn, tail_up, tail_dn, wr_addr, cap_last;
  logic             wr_en, full, empty;
  logic [CMP_W-1:0] cfg_ext, cap_sat_ext, count_ext;
  logic [CNT_W-1:0] cap_sat;
  mode_t            mode;

  assign mode     = mode_t'(in_mode);
  assign full     = (count_r >= cap_r);
  assign empty    = (count_r == '0);
  assign cap_last = IDX_W'(cap_r - CNT_W'(1));

  assign head_up = ((CNT_W'(head_r) + CNT_W'(1)) >= cap_r) ? '0 : head_r + IDX_W'(1);
  assign tail_up = ((CNT_W'(tail_r) + CNT_W'(1)) >= cap_r) ? '0 : tail_r + IDX_W'(1);
  assign head_dn = (head_r == '0) ? cap_last : head_r - IDX_W'(1);
  assign tail_dn = (tail_r == '0) ? cap_last : tail_r - IDX_W'(1);

  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    priority if (cfg_ext == '0) begin
      cap_sat_ext = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(DEPTH)) begin
      cap_sat_ext = CMP_W'(DEPTH);
    end else begin
      cap_sat_ext = cfg_ext;
    end
  end
  assign cap_sat = CNT_W'(cap_sat_ext);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = head_dn;
    if (cfg_wr_en) begin
      cap_nxt   = cap_sat;
      head_nxt  = '0;
      tail_nxt  = IDX_W'(cap_sat - CNT_W'(1));
      count_nxt = '0;
    end else if (cmd.exec) begin
      ok_nxt = 1'b0;
      unique case (mode)
        MODE_PUSH_FRONT: begin
          if (!full) begin
            head_nxt  = head_dn;
            wr_en     = 1'b1;
            wr_addr   = head_dn;
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        MODE_PUSH_REAR: begin
          if (!full) begin
            tail_nxt  = tail_up;
            wr_en     = 1'b1;
            wr_addr   = tail_up;
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (!empty) begin
            head_nxt  = head_up;
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        MODE_POP_REAR: begin
          if (!empty) begin
            tail_nxt  = tail_dn;
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        MODE_PEEK: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= IDX_W'(DEPTH - 1);
      count_r <= '0;
      cap_r   <= CNT_W'(DEPTH);
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rd_front_r <= mem[head_r];
    rd_rear_r  <= mem[tail_r];
  end

  assign count_ext = CMP_W'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_success     <= ok_r;
      out_front_word  <= empty ? '0 : rd_front_r;
      out_rear_word   <= empty ? '0 : rd_rear_r;
      out_is_empty    <= empty;
      out_is_full     <= (count_r == cap_r);
      out_entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("Entry count exceeds capacity.");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= CNT_W'(DEPTH)))
    else $error("Capacity register out of range.");

endmodule

// File: test/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [cdq_pkg::MODE_W-1:0]  in_mode,
  input  logic signed [WORD_BITS-1:0] in_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_success,
  input  logic signed [WORD_BITS-1:0] out_front_word,
  input  logic signed [WORD_BITS-1:0] out_rear_word,
  input  logic                        out_is_empty,
  input  logic                        out_is_full,
  input  logic [cdq_pkg::COUNT_W-1:0] out_entry_count,
  input  logic                        cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0]   cfg_wr_data,
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked,
  output int                          refused_seen,
  output int                          full_seen
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic                        success;
    logic signed [WORD_BITS-1:0] front_word;
    logic signed [WORD_BITS-1:0] rear_word;
    logic                        is_empty;
    logic                        is_full;
    logic [COUNT_W-1:0]          entry_count;
  } deque_view_t;

  logic signed [WORD_BITS-1:0] slots [DEPTH];
  logic [IDX_W-1:0]            head;
  logic [IDX_W-1:0]            tail;
  logic [COUNT_W-1:0]          held;
  logic [COUNT_W-1:0]          capacity;
  deque_view_t                 expected_views [$];

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    return (int'(idx) + 1 >= int'(capacity)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(capacity - 1'b1) : idx - 1'b1;
  endfunction

  function automatic void empty_deque();
    head = '0;
    tail = IDX_W'(capacity - 1'b1);
    held = '0;
  endfunction

  function automatic deque_view_t apply_request(input logic [MODE_W-1:0] mode,
                                                input logic signed [WORD_BITS-1:0] word);
    deque_view_t view;
    logic        full;
    full = (held >= capacity);
    view.success = 1'b0;
    case (mode)
      MODE_PUSH_FRONT: if (!full) begin
        head = prev_slot(head);
        slots[head] = word;
        held = held + 1'b1;
        view.success = 1'b1;
      end
      MODE_PUSH_REAR: if (!full) begin
        tail = next_slot(tail);
        slots[tail] = word;
        held = held + 1'b1;
        view.success = 1'b1;
      end
      MODE_POP_FRONT: if (held != '0) begin
        head = next_slot(head);
        held = held - 1'b1;
        view.success = 1'b1;
      end
      MODE_POP_REAR: if (held != '0) begin
        tail = prev_slot(tail);
        held = held - 1'b1;
        view.success = 1'b1;
      end
      MODE_PEEK: begin
        view.success = 1'b1;
      end
      default: begin
      end
    endcase
    view.front_word  = (held == '0) ? '0 : slots[head];
    view.rear_word   = (held == '0) ? '0 : slots[tail];
    view.is_empty    = (held == '0);
    view.is_full     = (held == capacity);
    view.entry_count = held;
    return view;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (!rst_n) begin
      capacity = COUNT_W'(DEPTH);
      empty_deque();
      expected_views.delete();
      fail_count      = 0;
      results_checked = 0;
      refused_seen    = 0;
      full_seen       = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          note_mismatch("result beat with no request waiting", 1, 0);
        end else begin
          want = expected_views.pop_front();
          results_checked++;
          if (out_success !== want.success)
            note_mismatch("success", longint'(out_success), longint'(want.success));
          if (out_front_word !== want.front_word)
            note_mismatch("front_word", longint'(out_front_word), longint'(want.front_word));
          if (out_rear_word !== want.rear_word)
            note_mismatch("rear_word", longint'(out_rear_word), longint'(want.rear_word));
          if (out_is_empty !== want.is_empty)
            note_mismatch("is_empty", longint'(out_is_empty), longint'(want.is_empty));
          if (out_is_full !== want.is_full)
            note_mismatch("is_full", longint'(out_is_full), longint'(want.is_full));
          if (out_entry_count !== want.entry_count)
            note_mismatch("entry_count", longint'(out_entry_count),
                          longint'(want.entry_count));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0)
          capacity = COUNT_W'(1);
        else if (int'(cfg_wr_data) > DEPTH)
          capacity = COUNT_W'(DEPTH);
        else
          capacity = cfg_wr_data;
        empty_deque();
      end
      if (in_valid && !in_stall) begin
        want = apply_request(in_mode, in_value);
        if (!want.success)
          refused_seen++;
        if (want.is_full)
          full_seen++;
        expected_views.push_back(want);
      end
    end
    pending = expected_views.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cdq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int WORD_BITS     = 32;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 100;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic [MODE_W-1:0]           in_mode     = '0;
  logic signed [WORD_BITS-1:0] in_value    = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic                        out_success;
  logic signed [WORD_BITS-1:0] out_front_word;
  logic signed [WORD_BITS-1:0] out_rear_word;
  logic                        out_is_empty;
  logic                        out_is_full;
  logic [COUNT_W-1:0]          out_entry_count;
  logic                        cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]            cfg_wr_data = '0;

  bit quiet            = 1'b0;
  int stall_left       = 0;
  int idle_cycles      = 0;
  int requests_sent    = 0;
  int settings_written = 0;
  int fail_count;
  int pending;
  int results_checked;
  int refused_seen;
  int full_seen;

  circular_double_ended_queue #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_success     (out_success),
    .out_front_word  (out_front_word),
    .out_rear_word   (out_rear_word),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  deque_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_success     (out_success),
    .out_front_word  (out_front_word),
    .out_rear_word   (out_rear_word),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .refused_seen    (refused_seen),
    .full_seen       (full_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return $urandom_range(1, 2);
    else if (r < 9)
      return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("No beat moved for %0d cycles, giving up.", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic [MODE_W-1:0] mode, input logic signed [WORD_BITS-1:0] word);
    int  gap;
    bit  taken;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= word;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_written++;
  endtask

  task automatic random_phase(input int items);
    int                run_left;
    bit                filling;
    int                r;
    logic [MODE_W-1:0] mode;
    run_left = 0;
    filling  = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (run_left == 0) begin
        filling  = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 4)
        mode = MODE_W'(MODE_UNUSED_LO + $urandom_range(0, MODE_UNUSED_HI - MODE_UNUSED_LO));
      else if (r < 10)
        mode = MODE_PEEK;
      else if ((r < 75) == filling)
        mode = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      else
        mode = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
      send(mode, random_word());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] caps [8];
    caps = '{5'd0, 5'd2, 5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd4};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty deque at the reset capacity: refusals, the unused modes and both ends.
    send(MODE_PEEK, WORD_MAX);
    send(MODE_POP_FRONT, '0);
    send(MODE_POP_REAR, '0);
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
      send(MODE_W'(m), WORD_MIN);
    send(MODE_PUSH_FRONT, WORD_MAX);
    send(MODE_PUSH_REAR, WORD_MIN);
    send(MODE_PUSH_FRONT, '1);
    send(MODE_PUSH_REAR, '0);
    send(MODE_PEEK, '0);
    send(MODE_POP_FRONT, '0);
    send(MODE_POP_REAR, '0);
    send(MODE_POP_REAR, '0);
    send(MODE_POP_FRONT, '0);
    send(MODE_POP_FRONT, '0);

    // A single slot is full after one insert.
    set_capacity(5'd1);
    send(MODE_PUSH_REAR, 32'sd5);
    send(MODE_PUSH_FRONT, 32'sd6);
    send(MODE_PUSH_REAR, 32'sd7);
    send(MODE_POP_REAR, '0);
    send(MODE_POP_FRONT, '0);
    send(MODE_PUSH_FRONT, WORD_MIN);
    send(MODE_POP_FRONT, '0);

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(p < 8 ? caps[p] : CFG_W'($urandom_range(0, 31)));
      quiet = (p % 5 == 3);
      random_phase(PHASE_ITEMS);
    end
    quiet = 1'b0;

    settle();
    $display("Sent %0d requests under %0d capacity settings after reset.",
             requests_sent, settings_written);
    $display("Compared %0d results: %0d refused, %0d with the deque full.",
             results_checked, refused_seen, full_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
